// ----- hdl/thfp_pkg.sv -----
package thfp_pkg;

	typedef enum logic [4:0] {
		PH_HDR, PH_VER, PH_TS, PH_RND, PH_SIDLEN, PH_SID, PH_CSLEN, PH_CS, PH_COMPLEN,
		PH_COMP, PH_SSUITE, PH_SCOMP, PH_EXTSLEN, PH_ETYPE, PH_ELEN, PH_EBODY,
		PH_CERTSLEN, PH_CLEN, PH_CBYTE, PH_SKIP, PH_SKIPREC
	} phase_t;

	localparam logic [3:0] TK_HEADER   = 4'd0;
	localparam logic [3:0] TK_VERSION  = 4'd1;
	localparam logic [3:0] TK_TSTAMP   = 4'd2;
	localparam logic [3:0] TK_RANDOM   = 4'd3;
	localparam logic [3:0] TK_SESSION  = 4'd4;
	localparam logic [3:0] TK_SUITE    = 4'd5;
	localparam logic [3:0] TK_COMP     = 4'd6;
	localparam logic [3:0] TK_EXTTYPE  = 4'd7;
	localparam logic [3:0] TK_EXTLEN   = 4'd8;
	localparam logic [3:0] TK_CERTLEN  = 4'd9;
	localparam logic [3:0] TK_CERTBYTE = 4'd10;
	localparam logic [3:0] TK_FINISHED = 4'd11;
	localparam logic [3:0] TK_ERROR    = 4'd12;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_HELLO      = 3'd1;
	localparam logic [2:0] ERR_SID        = 3'd2;
	localparam logic [2:0] ERR_SUITES     = 3'd3;
	localparam logic [2:0] ERR_SHELLO     = 3'd4;
	localparam logic [2:0] ERR_CERT       = 3'd5;

	localparam logic [7:0] MT_CLIENT_HELLO = 8'd1;
	localparam logic [7:0] MT_SERVER_HELLO = 8'd2;
	localparam logic [7:0] MT_CERTIFICATE  = 8'd11;
	localparam logic [7:0] MT_FINISHED     = 8'd20;

	localparam logic [23:0] MIN_HELLO    = 24'd35;
	localparam logic [5:0]  RANDOM_BYTES = 6'd28;

	localparam int unsigned OUTQ_DEPTH_DEF = 4;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        record_start;
		logic [15:0] record_length;
		logic        after_change_cipher;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [23:0] token_value;
		logic [7:0]  message_type;
		logic [2:0]  error_code;
		logic        last_token;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		out_item_t   tok;
	} tok_slot_t;

endpackage

// ----- hdl/thfp_core.sv -----
module thfp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  thfp_pkg::in_item_t item,
	input  logic              emit_raw,
	output thfp_pkg::tok_slot_t tok0,
	output thfp_pkg::tok_slot_t tok1
);
	import thfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [5:0]  fcnt_q, fcnt_d;
	logic [23:0] facc_q, facc_d;
	logic [23:0] mrem_q, mrem_d;
	logic [15:0] rrem_q, rrem_d;
	logic [23:0] lrem_q, lrem_d;
	logic [7:0]  ctype_q, ctype_d;
	logic        sknown_q, sknown_d;

	logic [3:0]  k0, k1;
	logic [23:0] v0, v1;
	logic [7:0]  t0, t1;
	logic [2:0]  e0, e1;
	logic [1:0]  n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			fcnt_q <= '0;
			facc_q <= '0;
			mrem_q <= '0;
			rrem_q <= '0;
			lrem_q <= '0;
			ctype_q <= '0;
			sknown_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			fcnt_q <= fcnt_d;
			facc_q <= facc_d;
			mrem_q <= mrem_d;
			rrem_q <= rrem_d;
			lrem_q <= lrem_d;
			ctype_q <= ctype_d;
			sknown_q <= sknown_d;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic [23:0] acc;
		logic [5:0]  cnt;
		logic        ok;
		logic [2:0]  code;
		b = item.data_byte;
		phase_d = phase_q;
		fcnt_d = fcnt_q;
		facc_d = facc_q;
		mrem_d = mrem_q;
		rrem_d = rrem_q;
		lrem_d = lrem_q;
		ctype_d = ctype_q;
		sknown_d = sknown_q;
		n = 2'd0;
		k0 = '0; v0 = '0; t0 = '0; e0 = '0;
		k1 = '0; v1 = '0; t1 = '0; e1 = '0;
		acc = '0;
		cnt = '0;
		ok = 1'b0;
		code = ERR_NONE;

		if (item.record_start) begin
			rrem_d = item.record_length;
			fcnt_d = '0;
			facc_d = '0;
			mrem_d = '0;
			lrem_d = '0;
			phase_d = PH_HDR;
			if (item.after_change_cipher) begin
				ctype_d = MT_FINISHED;
				k0 = TK_FINISHED; v0 = {8'd0, item.record_length}; t0 = MT_FINISHED;
				n = 2'd1;
				phase_d = PH_SKIPREC;
			end
		end

		if (rrem_d != 16'd0) begin
			rrem_d = rrem_d - 16'd1;
			acc = {facc_d[15:0], b};
			cnt = fcnt_d + 6'd1;
			if (phase_d == PH_SKIPREC) begin
			end else if (phase_d == PH_HDR) begin
				fcnt_d = cnt;
				if (cnt == 6'd1) begin
					ctype_d = b;
					facc_d = '0;
				end else begin
					facc_d = acc;
				end
				if (cnt >= 6'd4) begin
					k0 = TK_HEADER; v0 = facc_d; t0 = ctype_d; n = 2'd1;
					mrem_d = facc_d;
					fcnt_d = '0;
					facc_d = '0;
					lrem_d = '0;
					if (ctype_d == MT_CLIENT_HELLO || ctype_d == MT_SERVER_HELLO) begin
						if (mrem_d < MIN_HELLO) begin
							k1 = TK_ERROR; t1 = ctype_d; e1 = ERR_HELLO; n = 2'd2;
							phase_d = PH_SKIP;
						end else phase_d = PH_VER;
					end else if (ctype_d == MT_CERTIFICATE) begin
						if (mrem_d < 24'd3) begin
							k1 = TK_ERROR; t1 = ctype_d; e1 = ERR_CERT; n = 2'd2;
							phase_d = PH_SKIP;
						end else phase_d = PH_CERTSLEN;
					end else phase_d = PH_SKIP;
					if (mrem_d == 24'd0) phase_d = PH_HDR;
				end
			end else begin
				if (mrem_d != 24'd0) mrem_d = mrem_d - 24'd1;
				t0 = ctype_d; t1 = ctype_d;
				case (phase_d)
					PH_VER: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd2) begin
							k0 = TK_VERSION; v0 = {8'd0, acc[15:0]}; n = 2'd1;
							fcnt_d = '0; facc_d = '0; phase_d = PH_TS;
						end
					end
					PH_TS: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt == 6'd2 || cnt >= 6'd4) begin
							k0 = TK_TSTAMP; v0 = {8'd0, acc[15:0]}; n = 2'd1;
							facc_d = '0;
						end
						if (cnt >= 6'd4) begin
							fcnt_d = '0; facc_d = '0; phase_d = PH_RND;
						end
					end
					PH_RND: begin
						if (emit_raw) begin
							k0 = TK_RANDOM; v0 = {16'd0, b}; n = 2'd1;
						end
						fcnt_d = cnt;
						if (cnt >= RANDOM_BYTES) begin
							fcnt_d = '0; facc_d = '0; phase_d = PH_SIDLEN;
						end
					end
					PH_SIDLEN: begin
						if ({16'd0, b} > mrem_d) begin
							k0 = TK_ERROR; e0 = ERR_SID; n = 2'd1;
							fcnt_d = '0; facc_d = '0; phase_d = PH_SKIP;
						end else if (b == 8'd0) begin
							fcnt_d = '0; facc_d = '0;
							phase_d = (ctype_d == MT_CLIENT_HELLO) ? PH_CSLEN : PH_SSUITE;
						end else begin
							lrem_d = {16'd0, b}; phase_d = PH_SID;
						end
					end
					PH_SID: begin
						if (emit_raw) begin
							k0 = TK_SESSION; v0 = {16'd0, b}; n = 2'd1;
						end
						if (lrem_d != 24'd0) lrem_d = lrem_d - 24'd1;
						if (lrem_d == 24'd0) begin
							fcnt_d = '0; facc_d = '0;
							phase_d = (ctype_d == MT_CLIENT_HELLO) ? PH_CSLEN : PH_SSUITE;
						end
					end
					PH_CSLEN: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd2) begin
							fcnt_d = '0; facc_d = '0;
							if (acc > mrem_d) begin
								k0 = TK_ERROR; e0 = ERR_SUITES; n = 2'd1;
								phase_d = PH_SKIP;
							end else begin
								lrem_d = acc;
								phase_d = (acc != 24'd0) ? PH_CS : PH_COMPLEN;
							end
						end
					end
					PH_CS: begin
						if (lrem_d != 24'd0) lrem_d = lrem_d - 24'd1;
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd2) begin
							k0 = TK_SUITE; v0 = {8'd0, acc[15:0]}; n = 2'd1;
							fcnt_d = '0; facc_d = '0;
						end
						if (lrem_d == 24'd0) begin
							fcnt_d = '0; facc_d = '0; phase_d = PH_COMPLEN;
						end
					end
					PH_COMPLEN: begin
						if ({16'd0, b} > mrem_d) begin
							k0 = TK_ERROR; e0 = ERR_HELLO; n = 2'd1;
							fcnt_d = '0; facc_d = '0; phase_d = PH_SKIP;
						end else begin
							lrem_d = {16'd0, b};
							phase_d = (b != 8'd0) ? PH_COMP : PH_EXTSLEN;
						end
					end
					PH_COMP: begin
						k0 = TK_COMP; v0 = {16'd0, b}; n = 2'd1;
						if (lrem_d != 24'd0) lrem_d = lrem_d - 24'd1;
						if (lrem_d == 24'd0) phase_d = PH_EXTSLEN;
					end
					PH_SSUITE: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd2) begin
							k0 = TK_SUITE; v0 = {8'd0, acc[15:0]}; n = 2'd1;
							sknown_d = 1'b1;
							fcnt_d = '0; facc_d = '0; phase_d = PH_SCOMP;
						end
					end
					PH_SCOMP: begin
						k0 = TK_COMP; v0 = {16'd0, b}; n = 2'd1;
						phase_d = PH_EXTSLEN;
					end
					PH_EXTSLEN: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd2) begin
							fcnt_d = '0; facc_d = '0; phase_d = PH_ETYPE;
						end
					end
					PH_ETYPE: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd2) begin
							k0 = TK_EXTTYPE; v0 = {8'd0, acc[15:0]}; n = 2'd1;
							fcnt_d = '0; facc_d = '0; phase_d = PH_ELEN;
						end
					end
					PH_ELEN: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd2) begin
							k0 = TK_EXTLEN; v0 = {8'd0, acc[15:0]}; n = 2'd1;
							fcnt_d = '0; facc_d = '0;
							lrem_d = {8'd0, acc[15:0]};
							phase_d = (acc[15:0] != 16'd0) ? PH_EBODY : PH_ETYPE;
						end
					end
					PH_EBODY: begin
						if (lrem_d != 24'd0) lrem_d = lrem_d - 24'd1;
						if (lrem_d == 24'd0) phase_d = PH_ETYPE;
					end
					PH_CERTSLEN: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd3) begin
							lrem_d = acc;
							fcnt_d = '0; facc_d = '0;
							phase_d = (acc != 24'd0 && mrem_d != 24'd0) ? PH_CLEN : PH_SKIP;
						end
					end
					PH_CLEN: begin
						fcnt_d = cnt; facc_d = acc;
						if (cnt >= 6'd3) begin
							k0 = TK_CERTLEN; v0 = acc; n = 2'd1;
							if (lrem_d < 24'd3 || acc > lrem_d - 24'd3 || acc > mrem_d) begin
								k1 = TK_ERROR; e1 = ERR_CERT; n = 2'd2;
								fcnt_d = '0; facc_d = '0; phase_d = PH_SKIP;
							end else begin
								lrem_d = lrem_d - 24'd3;
								fcnt_d = '0;
								facc_d = acc;
								if (acc == 24'd0) begin
									facc_d = '0;
									phase_d = (lrem_d != 24'd0 && mrem_d != 24'd0) ?
										PH_CLEN : PH_SKIP;
								end else phase_d = PH_CBYTE;
							end
						end
					end
					PH_CBYTE: begin
						if (emit_raw) begin
							k0 = TK_CERTBYTE; v0 = {16'd0, b}; n = 2'd1;
						end
						if (facc_d != 24'd0) facc_d = facc_d - 24'd1;
						if (lrem_d != 24'd0) lrem_d = lrem_d - 24'd1;
						if (facc_d == 24'd0) begin
							fcnt_d = '0;
							phase_d = (lrem_d != 24'd0 && mrem_d != 24'd0) ? PH_CLEN : PH_SKIP;
						end
					end
					PH_SKIP: begin
					end
					default: phase_d = PH_SKIP;
				endcase
				if (mrem_d == 24'd0) begin
					ok = (phase_d == PH_EXTSLEN || phase_d == PH_ETYPE ||
						phase_d == PH_ELEN || phase_d == PH_EBODY || phase_d == PH_SKIP);
					if (!ok) begin
						if (ctype_d == MT_CLIENT_HELLO) code = ERR_HELLO;
						else if (ctype_d == MT_SERVER_HELLO) code = ERR_SHELLO;
						else if (ctype_d == MT_CERTIFICATE) code = ERR_CERT;
						if (code != ERR_NONE && n != 2'd2) begin
							if (n == 2'd0) begin
								k0 = TK_ERROR; v0 = '0; e0 = code; n = 2'd1;
							end else begin
								k1 = TK_ERROR; v1 = '0; e1 = code; n = 2'd2;
							end
						end
					end
					fcnt_d = '0; facc_d = '0; lrem_d = '0; phase_d = PH_HDR;
				end
			end
		end
	end

	assign tok0.valid = (n != 2'd0);
	assign tok0.tok = '{token_kind: k0, token_value: v0, message_type: t0,
		error_code: e0, last_token: (n == 2'd1)};
	assign tok1.valid = (n == 2'd2);
	assign tok1.tok = '{token_kind: k1, token_value: v1, message_type: t1,
		error_code: e1, last_token: 1'b1};

endmodule

// ----- hdl/thfp_outq.sv -----
module thfp_outq #(
	parameter int unsigned DEPTH = thfp_pkg::OUTQ_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  thfp_pkg::tok_slot_t tok0,
	input  thfp_pkg::tok_slot_t tok1,
	output logic               room,
	output logic               valid,
	output thfp_pkg::out_item_t data,
	input  logic               stall
);
	import thfp_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	out_item_t          mem_q [DEPTH];
	logic [AW-1:0]      wp_q, rp_q;
	logic [AW:0]        cnt_q;
	logic [AW-1:0]      wp1;
	logic [1:0]         nin;
	logic               pop;

	assign pop = valid && !stall;
	assign nin = (push && tok0.valid) ? (tok1.valid ? 2'd2 : 2'd1) : 2'd0;
	assign wp1 = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign room = (cnt_q <= (AW + 1)'(DEPTH - 2));
	assign valid = (cnt_q != '0);
	assign data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (nin != 2'd0) mem_q[wp_q] <= tok0.tok;
		if (nin == 2'd2) mem_q[wp1] <= tok1.tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (nin == 2'd1) wp_q <= wp1;
			else if (nin == 2'd2) wp_q <= (wp1 == AW'(DEPTH - 1)) ? '0 : wp1 + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(nin) - (AW + 1)'(pop);
		end
	end

endmodule

// ----- hdl/tls_handshake_field_parser.sv -----
// TLS handshake field parser.
// in_valid/in_stall carry one record payload byte per transaction with its
// record_start, record_length and after_change_cipher flags. out_valid/
// out_stall carry tokens; each byte yields zero, one or two tokens, and
// last_token marks the final token of a byte.
// cfg_valid/cfg_ready write emit_raw_bytes (bit 0 of cfg_data); ready is
// always high.
// An accepted byte's tokens are written into an OUTQ_DEPTH-entry token queue
// (four by default) at the edge that accepts the byte. The parser takes one
// byte per cycle while in_stall is low; a byte giving two tokens needs two
// output transfers, so sustained input rate follows output token rate.
// in_stall rises when fewer than two queue slots are free.
// Reset clears the parse state, empties the queue and sets emit_raw_bytes.
// While out_stall is high tokens hold in the queue; once fewer than two slots
// are free, in_stall holds the input side.
module tls_handshake_field_parser #(
	parameter int unsigned OUTQ_DEPTH = thfp_pkg::OUTQ_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  thfp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output thfp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import thfp_pkg::*;

	logic      emit_q;
	logic      room;
	logic      step;
	tok_slot_t tok0, tok1;

	assign cfg_ready = 1'b1;
	assign in_stall = !room;
	assign step = in_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_q <= 1'b1;
		else if (cfg_valid) emit_q <= cfg_data;
	end

	thfp_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .item(in_data),
		.emit_raw(emit_q), .tok0(tok0), .tok1(tok1)
	);

	thfp_outq #(.DEPTH(OUTQ_DEPTH)) u_outq (
		.clk(clk), .arst_n(arst_n), .push(step), .tok0(tok0), .tok1(tok1),
		.room(room), .valid(out_valid), .data(out_data), .stall(out_stall)
	);

endmodule

// ----- hdl/thfp_checker.sv -----
module thfp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input thfp_pkg::out_item_t out_data
);
	import thfp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled token changed");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_kind <= TK_ERROR)
		else $error("token kind out of range");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind != TK_ERROR |-> out_data.error_code == ERR_NONE)
		else $error("error code on non-error token");

	a_fin_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind == TK_FINISHED |->
		out_data.message_type == MT_FINISHED)
		else $error("finished token type");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no token pending");

endmodule

bind tls_handshake_field_parser thfp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- tb/sv/tls_handshake_field_parser_tb.sv -----
`timescale 1ns / 100ps

module tls_handshake_field_parser_tb;
	import thfp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	tls_handshake_field_parser #(.OUTQ_DEPTH(4)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser state mirror
	logic        raw_en = 1'b1;
	phase_t      ph = PH_HDR;
	logic [5:0]  fbc = '0;
	logic [23:0] facc = '0;
	logic [23:0] msg_left = '0;
	logic [15:0] rec_left = '0;
	logic [23:0] list_left = '0;
	logic [7:0]  cur_type = '0;
	logic        suite_seen = 1'b0;

	out_item_t   step_tok [2];
	int          step_n;
	out_item_t   tok_expect [$];
	in_item_t    byte_queue [$];
	logic [7:0]  msg [$];

	int          fails = 0;
	int          bytes_in = 0;
	int          toks_out = 0;
	int          records = 0;
	bit          calm = 1'b0;

	function automatic void add_byte(logic [7:0] b);
		msg = {msg, b};
	endfunction

	function automatic void emit_tok(logic [3:0] k, logic [23:0] v, logic [2:0] e);
		if (step_n < 2) begin
			step_tok[step_n].token_kind   = k;
			step_tok[step_n].token_value  = v;
			step_tok[step_n].message_type = cur_type;
			step_tok[step_n].error_code   = e;
			step_tok[step_n].last_token   = 1'b0;
			step_n++;
		end
	endfunction

	function automatic void clr_field();
		fbc = '0;
		facc = '0;
	endfunction

	function automatic void fail_msg(logic [2:0] e);
		emit_tok(TK_ERROR, '0, e);
		clr_field();
		ph = PH_SKIP;
	endfunction

	function automatic bit take(logic [7:0] b, int n);
		facc = {facc[15:0], b};
		fbc++;
		return fbc >= n;
	endfunction

	function automatic void after_sid();
		clr_field();
		ph = (cur_type == MT_CLIENT_HELLO) ? PH_CSLEN : PH_SSUITE;
	endfunction

	function automatic void cert_next();
		clr_field();
		ph = (list_left > 0 && msg_left > 0) ? PH_CLEN : PH_SKIP;
	endfunction

	function automatic void start_msg(logic [23:0] len);
		msg_left = len;
		clr_field();
		list_left = '0;
		if (cur_type == MT_CLIENT_HELLO || cur_type == MT_SERVER_HELLO) begin
			if (len < MIN_HELLO) fail_msg(ERR_HELLO);
			else ph = PH_VER;
		end else if (cur_type == MT_CERTIFICATE) begin
			if (len < 3) fail_msg(ERR_CERT);
			else ph = PH_CERTSLEN;
		end else begin
			ph = PH_SKIP;
		end
		if (msg_left == 0) ph = PH_HDR;
	endfunction

	function automatic void body_byte(logic [7:0] b);
		logic [23:0] v;
		case (ph)
			PH_VER: if (take(b, 2)) begin
				emit_tok(TK_VERSION, {8'd0, facc[15:0]}, ERR_NONE);
				clr_field();
				ph = PH_TS;
			end
			PH_TS: begin
				facc = {facc[15:0], b};
				fbc++;
				if (fbc == 2 || fbc >= 4) begin
					emit_tok(TK_TSTAMP, {8'd0, facc[15:0]}, ERR_NONE);
					facc = '0;
				end
				if (fbc >= 4) begin
					clr_field();
					ph = PH_RND;
				end
			end
			PH_RND: begin
				if (raw_en) emit_tok(TK_RANDOM, {16'd0, b}, ERR_NONE);
				fbc++;
				if (fbc >= RANDOM_BYTES) begin
					clr_field();
					ph = PH_SIDLEN;
				end
			end
			PH_SIDLEN: begin
				if ({16'd0, b} > msg_left) fail_msg(ERR_SID);
				else if (b == 0) after_sid();
				else begin
					list_left = {16'd0, b};
					ph = PH_SID;
				end
			end
			PH_SID: begin
				if (raw_en) emit_tok(TK_SESSION, {16'd0, b}, ERR_NONE);
				if (list_left > 0) list_left--;
				if (list_left == 0) after_sid();
			end
			PH_CSLEN: if (take(b, 2)) begin
				v = facc;
				clr_field();
				if (v > msg_left) fail_msg(ERR_SUITES);
				else begin
					list_left = v;
					ph = (v != 0) ? PH_CS : PH_COMPLEN;
				end
			end
			PH_CS: begin
				if (list_left > 0) list_left--;
				if (take(b, 2)) begin
					emit_tok(TK_SUITE, {8'd0, facc[15:0]}, ERR_NONE);
					clr_field();
				end
				if (list_left == 0) begin
					clr_field();
					ph = PH_COMPLEN;
				end
			end
			PH_COMPLEN: begin
				if ({16'd0, b} > msg_left) fail_msg(ERR_HELLO);
				else begin
					list_left = {16'd0, b};
					ph = (b != 0) ? PH_COMP : PH_EXTSLEN;
				end
			end
			PH_COMP: begin
				emit_tok(TK_COMP, {16'd0, b}, ERR_NONE);
				if (list_left > 0) list_left--;
				if (list_left == 0) ph = PH_EXTSLEN;
			end
			PH_SSUITE: if (take(b, 2)) begin
				emit_tok(TK_SUITE, {8'd0, facc[15:0]}, ERR_NONE);
				suite_seen = 1'b1;
				clr_field();
				ph = PH_SCOMP;
			end
			PH_SCOMP: begin
				emit_tok(TK_COMP, {16'd0, b}, ERR_NONE);
				ph = PH_EXTSLEN;
			end
			PH_EXTSLEN: if (take(b, 2)) begin
				clr_field();
				ph = PH_ETYPE;
			end
			PH_ETYPE: if (take(b, 2)) begin
				emit_tok(TK_EXTTYPE, {8'd0, facc[15:0]}, ERR_NONE);
				clr_field();
				ph = PH_ELEN;
			end
			PH_ELEN: if (take(b, 2)) begin
				v = {8'd0, facc[15:0]};
				emit_tok(TK_EXTLEN, v, ERR_NONE);
				clr_field();
				list_left = v;
				ph = (v != 0) ? PH_EBODY : PH_ETYPE;
			end
			PH_EBODY: begin
				if (list_left > 0) list_left--;
				if (list_left == 0) ph = PH_ETYPE;
			end
			PH_CERTSLEN: if (take(b, 3)) begin
				list_left = facc;
				cert_next();
			end
			PH_CLEN: if (take(b, 3)) begin
				v = facc;
				emit_tok(TK_CERTLEN, v, ERR_NONE);
				if (list_left < 3 || v > list_left - 3 || v > msg_left) begin
					fail_msg(ERR_CERT);
				end else begin
					list_left = list_left - 3;
					fbc = '0;
					facc = v;
					if (v == 0) cert_next();
					else ph = PH_CBYTE;
				end
			end
			PH_CBYTE: begin
				if (raw_en) emit_tok(TK_CERTBYTE, {16'd0, b}, ERR_NONE);
				if (facc > 0) facc--;
				if (list_left > 0) list_left--;
				if (facc == 0) cert_next();
			end
			PH_SKIP: ;
			default: ph = PH_SKIP;
		endcase
	endfunction

	function automatic void parse_byte(in_item_t it);
		logic [7:0] b;
		logic [2:0] code;
		b = it.data_byte;
		step_n = 0;
		if (it.record_start) begin
			rec_left = it.record_length;
			clr_field();
			msg_left = '0;
			list_left = '0;
			ph = PH_HDR;
			if (it.after_change_cipher) begin
				cur_type = MT_FINISHED;
				emit_tok(TK_FINISHED, {8'd0, rec_left}, ERR_NONE);
				ph = PH_SKIPREC;
			end
		end
		if (rec_left != 0) begin
			rec_left--;
			if (ph == PH_SKIPREC) begin
			end else if (ph == PH_HDR) begin
				fbc++;
				if (fbc == 1) begin
					cur_type = b;
					facc = '0;
				end else begin
					facc = {facc[15:0], b};
				end
				if (fbc >= 4) begin
					emit_tok(TK_HEADER, facc, ERR_NONE);
					start_msg(facc);
				end
			end else begin
				if (msg_left > 0) msg_left--;
				body_byte(b);
				if (msg_left == 0) begin
					if (!(ph inside {PH_EXTSLEN, PH_ETYPE, PH_ELEN, PH_EBODY, PH_SKIP})) begin
						code = ERR_NONE;
						if (cur_type == MT_CLIENT_HELLO) code = ERR_HELLO;
						else if (cur_type == MT_SERVER_HELLO) code = ERR_SHELLO;
						else if (cur_type == MT_CERTIFICATE) code = ERR_CERT;
						if (code != ERR_NONE) emit_tok(TK_ERROR, '0, code);
					end
					clr_field();
					list_left = '0;
					ph = PH_HDR;
				end
			end
		end
		for (int i = 0; i < step_n; i++) begin
			if (i == step_n - 1) step_tok[i].last_token = 1'b1;
			tok_expect = {tok_expect, step_tok[i]};
		end
	endfunction

	// input side
	bit byte_took = 1'b0;
	int in_gap = 0;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			parse_byte(in_data);
			bytes_in++;
			byte_took = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !byte_took)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (byte_queue.size() > 0) begin
				in_data <= byte_queue.pop_front();
				in_valid <= 1'b1;
				in_gap = calm ? 0 : $urandom_range(0, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
		byte_took = 1'b0;
	end

	// output side
	bit tok_took = 1'b0;
	int stall_left = 0;

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			toks_out++;
			tok_took = 1'b1;
			if (tok_expect.size() == 0) begin
				$error("unexpected token kind=%0d value=%0h", out_data.token_kind,
					out_data.token_value);
				fails++;
			end else begin
				want = tok_expect.pop_front();
				if (out_data.token_kind !== want.token_kind) begin
					$error("token_kind: expected %0d, got %0d", want.token_kind,
						out_data.token_kind);
					fails++;
				end
				if (out_data.token_value !== want.token_value) begin
					$error("token_value: expected %0h, got %0h", want.token_value,
						out_data.token_value);
					fails++;
				end
				if (out_data.message_type !== want.message_type) begin
					$error("message_type: expected %0d, got %0d", want.message_type,
						out_data.message_type);
					fails++;
				end
				if (out_data.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						out_data.error_code);
					fails++;
				end
				if (out_data.last_token !== want.last_token) begin
					$error("last_token: expected %0b, got %0b", want.last_token,
						out_data.last_token);
					fails++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (tok_took) begin
				stall_left = calm ? 0 : $urandom_range(0, 5);
				tok_took = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// stimulus builders
	function automatic void put_rand(int n);
		for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_be(int v, int n);
		for (int i = n - 1; i >= 0; i--) add_byte(8'((v >> (8 * i)) & 255));
	endfunction

	// header + body taken from body_q; length adjusted by len_adj
	function automatic void wrap_msg(logic [7:0] mt, logic [7:0] body_q [$], int len_adj,
		bit poke);
		int len;
		len = body_q.size() + len_adj;
		if (len < 0) len = 0;
		if (poke && body_q.size() > 0)
			body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
		add_byte(mt);
		put_be(len, 3);
		for (int i = 0; i < len; i++)
			add_byte(i < body_q.size() ? body_q[i] : 8'($urandom_range(0, 255)));
	endfunction

	function automatic void add_hello(logic [7:0] mt, int sid_n, int cs_n, int comp_n,
		int ext_n, int len_adj, bit poke);
		logic [7:0] saved [$];
		logic [7:0] body [$];
		int el;
		saved = msg;
		msg = {};
		put_rand(2 + 4 + 28);
		add_byte(8'(sid_n));
		put_rand(sid_n);
		if (mt == MT_CLIENT_HELLO) begin
			put_be(cs_n, 2);
			put_rand(cs_n);
			add_byte(8'(comp_n));
			put_rand(comp_n);
		end else begin
			put_rand(3);
		end
		put_rand(2);
		for (int i = 0; i < ext_n; i++) begin
			el = $urandom_range(0, 6);
			put_rand(2);
			put_be(el, 2);
			put_rand(el);
		end
		body = msg;
		msg = saved;
		wrap_msg(mt, body, len_adj, poke);
	endfunction

	function automatic void add_cert(int n, int len_adj, bit poke);
		logic [7:0] saved [$];
		logic [7:0] body [$];
		int lens [$];
		int tot;
		tot = 0;
		for (int i = 0; i < n; i++) begin
			lens = {lens, int'($urandom_range(0, 12))};
			tot += 3 + lens[i];
		end
		saved = msg;
		msg = {};
		put_be(tot, 3);
		foreach (lens[i]) begin
			put_be(lens[i], 3);
			put_rand(lens[i]);
		end
		body = msg;
		msg = saved;
		wrap_msg(MT_CERTIFICATE, body, len_adj, poke);
	endfunction

	function automatic void add_other(logic [7:0] mt, int len);
		add_byte(mt);
		put_be(len, 3);
		put_rand(len);
	endfunction

	function automatic in_item_t mk_byte(logic [7:0] b, bit st, logic [15:0] len, bit acc);
		in_item_t it;
		it.data_byte = b;
		it.record_start = st;
		it.record_length = st ? len : 16'($urandom);
		it.after_change_cipher = st ? acc : 1'($urandom_range(0, 1));
		return it;
	endfunction

	// ship msg as one record; rec_adj shifts the stated record length
	function automatic void send_record(int rec_adj);
		int len;
		len = msg.size() + rec_adj;
		if (len < 0) len = 0;
		if (len > 65535) len = 65535;
		foreach (msg[i]) byte_queue = {byte_queue, mk_byte(msg[i], i == 0, 16'(len), 1'b0)};
		msg = {};
		records++;
	endfunction

	function automatic void send_finished(logic [15:0] len, int nb);
		for (int i = 0; i < nb; i++)
			byte_queue = {byte_queue,
				mk_byte(8'($urandom_range(0, 255)), i == 0, len, 1'b1)};
		records++;
	endfunction

	function automatic void send_stray(int nb);
		for (int i = 0; i < nb; i++)
			byte_queue = {byte_queue, mk_byte(8'($urandom_range(0, 255)), 1'b0, '0, 1'b0)};
	endfunction

	function automatic void random_record();
		int k;
		int nm;
		nm = $urandom_range(1, 2);
		k = $urandom_range(0, 99);
		if (k < 8) begin
			send_finished(16'($urandom), $urandom_range(1, 4));
			return;
		end
		if (k < 11) begin
			send_stray($urandom_range(1, 3));
			return;
		end
		for (int m = 0; m < nm; m++) begin
			k = $urandom_range(0, 99);
			if (k < 35)
				add_hello(MT_CLIENT_HELLO, $urandom_range(0, 32),
					$urandom_range(0, 6) * 2 + ($urandom_range(0, 9) == 0),
					$urandom_range(0, 3), $urandom_range(0, 3),
					($urandom_range(0, 9) < 8) ? 0 : $urandom_range(0, 25) - 20,
					$urandom_range(0, 9) == 0);
			else if (k < 60)
				add_hello(MT_SERVER_HELLO, $urandom_range(0, 32), 0, 0,
					$urandom_range(0, 3),
					($urandom_range(0, 9) < 8) ? 0 : $urandom_range(0, 25) - 20,
					$urandom_range(0, 9) == 0);
			else if (k < 85)
				add_cert($urandom_range(0, 3),
					($urandom_range(0, 9) < 8) ? 0 : $urandom_range(0, 10) - 8,
					$urandom_range(0, 9) == 0);
			else
				add_other(8'($urandom_range(0, 255)), $urandom_range(0, 10));
		end
		send_record(($urandom_range(0, 9) < 8) ? 0 : $urandom_range(0, 10) - 5);
	endfunction

	task automatic wait_drained();
		while (byte_queue.size() > 0 || in_valid || tok_expect.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_raw(bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		raw_en = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int n);
		int goal;
		goal = bytes_in + byte_queue.size() + n;
		while (bytes_in + byte_queue.size() < goal) begin
			random_record();
			while (byte_queue.size() > 40) @(posedge clk);
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes and each error path
		add_hello(MT_CLIENT_HELLO, 32, 4, 1, 2, 0, 0);
		send_record(0);
		add_hello(MT_SERVER_HELLO, 0, 0, 0, 1, 0, 0);
		send_record(0);
		add_other(MT_CLIENT_HELLO, 10);
		send_record(0);
		add_hello(MT_CLIENT_HELLO, 0, 0, 0, 0, -8, 0);
		send_record(0);
		add_hello(MT_SERVER_HELLO, 3, 0, 0, 0, -4, 0);
		send_record(0);
		add_hello(MT_CLIENT_HELLO, 40, 2, 1, 0, -20, 0);
		send_record(0);
		add_hello(MT_CLIENT_HELLO, 0, 20, 1, 0, -15, 0);
		send_record(0);
		add_hello(MT_CLIENT_HELLO, 0, 10, 10, 0, -9, 0);
		send_record(0);
		add_hello(MT_CLIENT_HELLO, 1, 5, 2, 1, 0, 0);
		send_record(0);
		add_hello(MT_SERVER_HELLO, 2, 0, 0, 2, -3, 0);
		send_record(0);
		add_cert(2, 0, 0);
		send_record(0);
		add_other(MT_CERTIFICATE, 2);
		send_record(0);
		add_cert(2, -6, 0);
		send_record(0);
		add_other(8'd0, 0);
		add_other(8'd255, 3);
		send_record(0);
		add_byte(8'd255);
		put_be(24'hFFFFFF, 3);
		put_rand(3);
		send_record(0);
		send_finished(16'hFFFF, 2);
		send_finished(16'h0000, 1);
		send_stray(3);
		add_cert(1, 0, 0);
		send_record(-5);
		wait_drained();

		write_raw(1'b0);
		random_phase(200);
		write_raw(1'b1);
		calm = 1'b1;
		random_phase(100);
		calm = 1'b0;
		random_phase(200);
		write_raw(1'b0);
		random_phase(100);
		write_raw(1'b1);
		random_phase(50);

		$display("covered %0d records, %0d bytes in, %0d tokens checked, %0d mismatches",
			records, bytes_in, toks_out, fails);
		if (fails == 0 && tok_expect.size() == 0)
			$display("tls_handshake_field_parser_tb: PASS");
		else
			$display("tls_handshake_field_parser_tb: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout: %0d tokens still pending", tok_expect.size());
		$display("tls_handshake_field_parser_tb: FAIL");
		$finish;
	end

endmodule
